/* src/scg_pkg.sv */
package scg_pkg;

  localparam int unsigned CHANNELS = 256;
  localparam int unsigned ChIdxW   = $clog2(CHANNELS);
  localparam int unsigned IdxW     = 8;
  localparam int unsigned ProbW    = 25;
  localparam int unsigned ThrW     = ProbW + 2;
  localparam int unsigned CntW     = 9;
  localparam int unsigned NumRegs  = 8;
  localparam int unsigned RegIdxW  = $clog2(NumRegs);

  localparam logic [CntW-1:0] CountMax = '1;

  typedef logic [ProbW-1:0] prob_t;
  typedef logic [ThrW-1:0]  thr_t;

  typedef enum logic [RegIdxW-1:0] {
    REG_ACTIVATE        = 3'd0,
    REG_DEACTIVATE      = 3'd1,
    REG_OPEN_READY      = 3'd2,
    REG_LEAVE_READY     = 3'd3,
    REG_VOLT_RECOVER    = 3'd4,
    REG_VOLT_INACTIVATE = 3'd5,
    REG_CA_RECOVER      = 3'd6,
    REG_CA_INACTIVATE   = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    LVL_CLOSED = 2'd0,
    LVL_INTER  = 2'd1,
    LVL_READY  = 2'd2,
    LVL_UNUSED = 2'd3
  } level_e;

  typedef struct packed {
    level_e level;
    logic   volt;
    logic   ca;
  } chan_state_t;

  localparam chan_state_t StateReset = '{level: LVL_CLOSED, volt: 1'b1, ca: 1'b1};

  typedef struct packed {
    chan_state_t nxt;
    logic        open;
  } upd_t;

  typedef struct packed {
    logic              en;
    logic [ChIdxW-1:0] idx;
    chan_state_t       data;
  } mem_wr_t;

endpackage

/* src/scg_if.sv */
interface scg_in_if import scg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [IdxW-1:0]     channel_index;
  logic [ProbW-1:0]    draw_value;
  logic                sweep_last;

  modport source(output valid, output channel_index, output draw_value,
                 output sweep_last, input ready);
  modport sink(input valid, input channel_index, input draw_value,
               input sweep_last, output ready);
endinterface

interface scg_out_if import scg_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            channel_open;
  logic [CntW-1:0] open_total;
  logic            sweep_done;

  modport source(output valid, output channel_open, output open_total,
                 output sweep_done, input ready);
  modport sink(input valid, input channel_open, input open_total,
               input sweep_done, output ready);
endinterface

interface scg_cfg_if import scg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RegIdxW-1:0] reg_index;
  logic [ProbW-1:0]   data;

  modport source(output valid, output reg_index, output data, input ready);
  modport sink(input valid, input reg_index, input data, output ready);
endinterface

/* src/scg_cfg_regs.sv */
module scg_cfg_regs import scg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  scg_cfg_if.sink     cfg_i,
  output prob_t       probs_o [NumRegs]
);

  prob_t probs_q [NumRegs];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        probs_q[i] <= '0;
      end
    end else if (cfg_i.valid) begin
      probs_q[cfg_i.reg_index] <= cfg_i.data;
    end
  end

  assign probs_o = probs_q;

endmodule

/* src/scg_state_mem.sv */
module scg_state_mem import scg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [ChIdxW-1:0] rd_idx_i,
  input  mem_wr_t           wr_i,
  output chan_state_t       rd_data_o
);

  chan_state_t mem [CHANNELS];
  logic [CHANNELS-1:0] vld_q;
  chan_state_t rd_q;
  chan_state_t fwd_q;
  logic        rd_vld_q;
  logic        hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.idx] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_q  <= mem[rd_idx_i];
      fwd_q <= wr_i.data;
    end
  end

  // a write on the same edge as the read is not seen by the array read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.idx] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_idx_i];
        hit_q    <= wr_i.en && (wr_i.idx == rd_idx_i);
      end
    end
  end

  // entries never written read as the reset state
  assign rd_data_o = hit_q    ? fwd_q :
                     rd_vld_q ? rd_q  : StateReset;

endmodule

/* src/scg_update.sv */
module scg_update import scg_pkg::*; (
  input  chan_state_t state_i,
  input  prob_t       rand_i,
  input  prob_t       probs_i [NumRegs],
  output upd_t        upd_o
);

  thr_t        r;
  thr_t        t_first;
  thr_t        t_base;
  thr_t        t_volt;
  thr_t        t_ca;
  logic        act_hit;
  logic        mid_hit;
  logic        volt_hit;
  logic        ca_hit;
  logic        do_avail;
  chan_state_t nxt;

  assign r = thr_t'(rand_i);

  // first activation threshold and the cumulative base for availability
  always_comb begin
    t_first = '0;
    t_base  = '0;
    unique case (state_i.level)
      LVL_CLOSED: begin
        t_first = thr_t'(probs_i[REG_ACTIVATE]);
        t_base  = t_first;
      end
      LVL_INTER: begin
        t_first = thr_t'(probs_i[REG_DEACTIVATE]);
        t_base  = t_first + thr_t'(probs_i[REG_OPEN_READY]);
      end
      LVL_READY: begin
        t_first = thr_t'(probs_i[REG_LEAVE_READY]);
        t_base  = t_first;
      end
      default: begin
        t_first = '0;
        t_base  = '0;
      end
    endcase
  end

  assign t_volt = t_base + thr_t'(state_i.volt ? probs_i[REG_VOLT_INACTIVATE]
                                               : probs_i[REG_VOLT_RECOVER]);
  assign t_ca   = t_volt + thr_t'(state_i.ca ? probs_i[REG_CA_INACTIVATE]
                                             : probs_i[REG_CA_RECOVER]);

  assign act_hit  = (r <= t_first);
  assign mid_hit  = (r <= t_base);
  assign volt_hit = (r <= t_volt);
  assign ca_hit   = (r <= t_ca);

  always_comb begin
    nxt      = state_i;
    do_avail = 1'b0;
    unique case (state_i.level)
      LVL_CLOSED: begin
        if (act_hit) nxt.level = LVL_INTER;
        else         do_avail  = 1'b1;
      end
      LVL_INTER: begin
        if (act_hit)      nxt.level = LVL_CLOSED;
        else if (mid_hit) nxt.level = LVL_READY;
        else              do_avail  = 1'b1;
      end
      LVL_READY: begin
        if (act_hit) nxt.level = LVL_INTER;
        else         do_avail  = 1'b1;
      end
      default: begin
        do_avail = 1'b0;
      end
    endcase
    if (do_avail) begin
      if (volt_hit) begin
        nxt.volt = !state_i.volt;
      end else if (ca_hit) begin
        nxt.ca = !state_i.ca;
      end
    end
  end

  assign upd_o.nxt  = nxt;
  assign upd_o.open = (nxt.level == LVL_READY) && nxt.volt && nxt.ca;

endmodule

/* src/stochastic_channel_gating_step_unit.sv */
// path: an accepted beat is registered in stage one, then in the output register
// throughput: one beat per cycle while out_o.ready holds; the state read issued
// at acceptance is written back when the beat leaves stage one, forwarded on a back to back hit
// reset: probability registers and the open count go to zero, and every
// channel reads as closed with both availability bits set until first written
module stochastic_channel_gating_step_unit import scg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  scg_cfg_if.sink  cfg_i,
  scg_in_if.sink   in_i,
  scg_out_if.source out_o
);

  prob_t       probs [NumRegs];
  chan_state_t cur_state;
  upd_t        upd;
  mem_wr_t     wr;

  logic              s1_vld_q;
  logic [IdxW-1:0]   s1_idx_q;
  prob_t             s1_rand_q;
  logic              s1_last_q;
  logic [CntW-1:0]   cnt_q;
  logic [CntW-1:0]   cnt_inc;
  logic              out_vld_q;
  logic              out_open_q;
  logic [CntW-1:0]   out_total_q;
  logic              out_done_q;

  logic out_free;
  logic s1_adv;
  logic in_acc;
  logic in_range;
  logic open_eff;

  scg_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .probs_o (probs)
  );

  assign out_free   = !out_vld_q || out_o.ready;
  assign s1_adv     = s1_vld_q && out_free;
  assign in_i.ready = !s1_vld_q || out_free;
  assign in_acc     = in_i.valid && in_i.ready;

  assign in_range = (32'(s1_idx_q) < CHANNELS);

  assign wr.en   = s1_adv && in_range;
  assign wr.idx  = s1_idx_q[ChIdxW-1:0];
  assign wr.data = upd.nxt;

  scg_state_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_idx_i  (in_i.channel_index[ChIdxW-1:0]),
    .wr_i      (wr),
    .rd_data_o (cur_state)
  );

  scg_update u_upd (
    .state_i (cur_state),
    .rand_i  (s1_rand_q),
    .probs_i (probs),
    .upd_o   (upd)
  );

  // count saturates
  assign open_eff = in_range && upd.open;
  assign cnt_inc  = (open_eff && (cnt_q != CountMax)) ? cnt_q + CntW'(1) : cnt_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_idx_q  <= in_i.channel_index;
      s1_rand_q <= in_i.draw_value;
      s1_last_q <= in_i.sweep_last;
    end
    if (s1_adv) begin
      out_open_q  <= open_eff;
      out_total_q <= cnt_inc;
      out_done_q  <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_q <= 1'b1;
        cnt_q     <= s1_last_q ? '0 : cnt_inc;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.channel_open = out_open_q;
  assign out_o.open_total   = out_total_q;
  assign out_o.sweep_done   = out_done_q;

endmodule
